// File: rtl/core/assert_macros.svh
// assertion macros shared by the convolution rtl
// no dependencies; macros are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	`ASSERT_AT(lbl, !(cond), msg)
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/rcc_pkg.sv
// shared types and constants for the rgb 5x5 convolution
// no dependencies
package rcc_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 18;
	localparam int IDX_W        = 5;
	localparam int PROD_W       = COEF_W + SAMPLE_W + 1;
	localparam int FRAC_BITS    = 12;
	localparam int ONE_Q15      = 32768;
	localparam int ROW_W        = 12;
	localparam int COL_W        = 10;
	localparam int HEIGHT_W     = 13;
	localparam int CFG_W        = 13;
	localparam int WREG_W       = 11;
	localparam int MAX_HEIGHT   = 4096;
	localparam int FIFO_DEPTH   = 8;
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 72;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_DRAIN = 2'd1,
		OP_COEF  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic                     shift;
		logic                     load;
		logic [IDX_W-1:0]         index;
		logic signed [COEF_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} meta_t;

endpackage

// File: rtl/core/rcc_ram.sv
// generic single write port ram with registered read
// no dependencies
module rcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/rcc_line_buf.sv
// one image line of delay, built on rcc_ram with a prefetched read
// depends on rcc_ram
module rcc_line_buf #(
	parameter int W     = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [$clog2(DEPTH)-1:0] addr_nxt,
	input  logic [W-1:0]             din,
	output logic [W-1:0]             dout
);

	logic [$clog2(DEPTH)-1:0] raddr;
	logic [W-1:0]             rdata;
	logic                     byp_q;
	logic [W-1:0]             byp_data_q;

	// read ahead so the word at the current address is ready at accept
	assign raddr = en ? addr_nxt : addr;

	rcc_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (en),
		.waddr (addr),
		.wdata (din),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= en && (addr_nxt == addr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= din;
	end

	assign dout = byp_q ? byp_data_q : rdata;

endmodule

// File: rtl/core/rcc_cell.sv
// one window tap: sample register, coefficient register and product
// depends on rcc_pkg
module rcc_cell #(
	parameter int CH  = 3,
	parameter int TAP = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcc_pkg::cell_ctl_t                  ctl,
	input  logic                                gate,
	input  logic [CH*rcc_pkg::SAMPLE_W-1:0]     din,
	output logic [CH*rcc_pkg::SAMPLE_W-1:0]     dout,
	output logic [CH*rcc_pkg::PROD_W-1:0]       prod_s2
);

	localparam int SW = rcc_pkg::SAMPLE_W;
	localparam int PW = rcc_pkg::PROD_W;

	logic signed [rcc_pkg::COEF_W-1:0] coef_q;
	logic [CH*SW-1:0]                  smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctl.load && (ctl.index == rcc_pkg::IDX_W'(TAP))) begin
			coef_q <= ctl.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			smp_q <= din;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < CH; ch++) begin
			if (gate) begin
				prod_s2[ch*PW +: PW] <= coef_q * $signed({1'b0, smp_q[ch*SW +: SW]});
			end else begin
				prod_s2[ch*PW +: PW] <= '0;
			end
		end
	end

	assign dout = smp_q;

endmodule

// File: rtl/core/rgb_conv2d_5x5_clamp.sv
// streaming 5x5 convolution of an rgb raster with zero padding and clamp
// depends on rcc_pkg, rcc_cell, rcc_line_buf, assert_macros.svh
//
// channel   dir  fields
// s_*       in   tuser: op; tdata: in_red, in_green, in_blue, coef_index, coef_value
// m_*       out  tdata: out_red, out_green, out_blue, out_row, out_col; tlast: frame_last
// cfg_*     in   write of image_width (index 0) or image_height (index 1)
//
// one word per cycle in and out while s_tready and m_tready are high; after the word
// that completes its window, a result passes stages s1 to s4 into an 8-word output queue
// s_tready drops only while queued plus in-flight results could fill that queue
// reset clears position and coefficients and sets the default geometry; line memories need no clearing
module rgb_conv2d_5x5_clamp #(
	parameter int MAX_WIDTH    = 1024,
	parameter int MASK_SIZE    = 5,
	parameter int NUM_CHANNELS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// in_red, in_green, in_blue, coef_index, coef_value
	input  logic [rcc_pkg::IN_DATA_W-1:0]    s_tdata,
	// op
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_red, out_green, out_blue, out_row, out_col
	output logic [rcc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [rcc_pkg::CFG_W-1:0]        cfg_data
);

	localparam int M     = MASK_SIZE;
	localparam int R     = MASK_SIZE / 2;
	localparam int TAPS  = MASK_SIZE * MASK_SIZE;
	localparam int CH    = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;
	localparam int SW    = rcc_pkg::SAMPLE_W;
	localparam int PXW   = CH * SW;
	localparam int PW    = rcc_pkg::PROD_W;
	localparam int RSW   = PW + $clog2(MASK_SIZE);
	localparam int ACW   = RSW + $clog2(MASK_SIZE);
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = rcc_pkg::HEIGHT_W;
	localparam int LW    = $clog2(R * MAX_WIDTH + R + 1);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int FD    = rcc_pkg::FIFO_DEPTH;
	localparam int FAW   = $clog2(FD);
	localparam int FCW   = $clog2(FD + 1);
	localparam int FW    = 3 * SW + rcc_pkg::ROW_W + rcc_pkg::COL_W + 1;

	rcc_pkg::op_t       op;
	logic               acc;
	logic               item;
	rcc_pkg::cell_ctl_t ctl;
	logic [PXW-1:0]     x_in;

	logic [WW-1:0]      weff_q;
	logic [HW-1:0]      heff_q;
	logic [LW-1:0]      lag_q;
	logic [13:0]        wv;
	logic [WW-1:0]      weff_new;
	logic [HW-1:0]      heff_new;

	logic [LW-1:0]      pre_q;
	logic [rcc_pkg::ROW_W-1:0] r_q;
	logic [AW-1:0]      c_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      ptr_nxt;
	logic               run;
	logic               c_end;
	logic               r_end;

	logic [M-1:0]       row_ok;
	logic [M-1:0]       col_ok;
	logic [TAPS-1:0]    gate_s1;
	logic               v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	rcc_pkg::meta_t     meta_s1, meta_s2, meta_s3, meta_s4;

	logic [PXW-1:0]     row_in [M];
	logic [PXW-1:0]     chain [M][M];
	logic [CH*PW-1:0]   prod_s2 [M][M];
	logic signed [RSW-1:0] rs_d [M][CH];
	logic signed [RSW-1:0] rsum_s3 [M][CH];
	logic signed [ACW-1:0] tot_d [CH];
	logic signed [ACW-1:0] acc_s4 [CH];
	logic [SW-1:0]      res [3];

	logic [FW-1:0]      fifo_q [FD];
	logic [FAW-1:0]     wp_q, rp_q;
	logic [FCW-1:0]     cnt_q;
	logic               push, pop;
	logic [4:0]         occ;

	assign op   = rcc_pkg::op_t'(s_tuser);
	assign acc  = s_tvalid && s_tready;
	assign item = acc && ((op == rcc_pkg::OP_PIXEL) || (op == rcc_pkg::OP_DRAIN));
	assign x_in = (op == rcc_pkg::OP_PIXEL) ? s_tdata[PXW-1:0] : '0;

	assign ctl.shift = item;
	assign ctl.load  = acc && (op == rcc_pkg::OP_COEF);
	assign ctl.index = s_tdata[52:48];
	assign ctl.value = s_tdata[70:53];

	// geometry clamp
	always_comb begin
		wv = 14'(cfg_data[rcc_pkg::WREG_W-1:0]);
		if (wv == 14'd0) begin
			weff_new = WW'(1);
		end else if (wv > 14'(MAX_WIDTH)) begin
			weff_new = WW'(MAX_WIDTH);
		end else begin
			weff_new = WW'(wv);
		end
		if (cfg_data == '0) begin
			heff_new = HW'(1);
		end else if (cfg_data > HW'(rcc_pkg::MAX_HEIGHT)) begin
			heff_new = HW'(rcc_pkg::MAX_HEIGHT);
		end else begin
			heff_new = cfg_data;
		end
	end

	assign run     = (pre_q == lag_q);
	assign c_end   = (WW'(c_q) + WW'(1)) == weff_q;
	assign r_end   = (HW'(r_q) + HW'(1)) == heff_q;
	assign ptr_nxt = ((WW'(ptr_q) + WW'(1)) == weff_q) ? '0 : ptr_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weff_q <= WW'(W_RST);
			heff_q <= HW'(1024);
			lag_q  <= LW'(R * W_RST + R);
			pre_q  <= '0;
			r_q    <= '0;
			c_q    <= '0;
			ptr_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rcc_pkg::REG_WIDTH: begin
					weff_q <= weff_new;
					lag_q  <= LW'(weff_new) * LW'(R) + LW'(R);
				end
				rcc_pkg::REG_HEIGHT: begin
					heff_q <= heff_new;
				end
				default: ;
			endcase
			pre_q <= '0;
			r_q   <= '0;
			c_q   <= '0;
			ptr_q <= '0;
		end else if (item) begin
			ptr_q <= ptr_nxt;
			if (!run) begin
				pre_q <= pre_q + LW'(1);
			end else if (c_end && r_end) begin
				pre_q <= '0;
				r_q   <= '0;
				c_q   <= '0;
			end else if (c_end) begin
				c_q <= '0;
				r_q <= r_q + rcc_pkg::ROW_W'(1);
			end else begin
				c_q <= c_q + AW'(1);
			end
		end
	end

	// which mask rows and columns fall inside the image
	always_comb begin
		logic signed [14:0] nr;
		logic signed [14:0] nc;
		for (int i = 0; i < M; i++) begin
			nr = $signed(15'(r_q)) + $signed(15'(i - R));
			nc = $signed(15'(c_q)) + $signed(15'(i - R));
			row_ok[i] = (nr >= 0) && (nr < $signed(15'(heff_q)));
			col_ok[i] = (nc >= 0) && (nc < $signed(15'(weff_q)));
		end
	end

	always_ff @(posedge clk) begin
		if (item) begin
			for (int i = 0; i < M; i++) begin
				for (int j = 0; j < M; j++) begin
					gate_s1[i*M + j] <= row_ok[i] && col_ok[j];
				end
			end
			meta_s1.last <= c_end && r_end;
			meta_s1.row  <= r_q;
			meta_s1.col  <= rcc_pkg::COL_W'(c_q);
		end
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else begin
			v_s1_q <= item && run;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q;
		end
	end

	// line delays feed the rows, each row is a chain of cells
	assign row_in[0] = x_in;

	for (genvar k = 0; k < M - 1; k++) begin : g_lb
		rcc_line_buf #(.W(PXW), .DEPTH(MAX_WIDTH)) u_lb (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (item),
			.addr     (ptr_q),
			.addr_nxt (ptr_nxt),
			.din      (row_in[k]),
			.dout     (row_in[k+1])
		);
	end

	for (genvar k = 0; k < M; k++) begin : g_row
		assign chain[k][0] = row_in[k];
		for (genvar m = 0; m < M; m++) begin : g_col
			if (m < M - 1) begin : g_mid
				rcc_cell #(.CH(CH), .TAP((M - 1 - k) * M + (M - 1 - m))) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.gate    (gate_s1[(M - 1 - k) * M + (M - 1 - m)]),
					.din     (chain[k][m]),
					.dout    (chain[k][m+1]),
					.prod_s2 (prod_s2[k][m])
				);
			end else begin : g_end
				rcc_cell #(.CH(CH), .TAP((M - 1 - k) * M + (M - 1 - m))) u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.gate    (gate_s1[(M - 1 - k) * M + (M - 1 - m)]),
					.din     (chain[k][m]),
					.dout    (),
					.prod_s2 (prod_s2[k][m])
				);
			end
		end
	end

	// row sums, then total
	always_comb begin
		for (int k = 0; k < M; k++) begin
			for (int ch = 0; ch < CH; ch++) begin
				rs_d[k][ch] = '0;
				for (int m = 0; m < M; m++) begin
					rs_d[k][ch] = rs_d[k][ch] + RSW'($signed(prod_s2[k][m][ch*PW +: PW]));
				end
			end
		end
		for (int ch = 0; ch < CH; ch++) begin
			tot_d[ch] = '0;
			for (int k = 0; k < M; k++) begin
				tot_d[ch] = tot_d[ch] + ACW'(rsum_s3[k][ch]);
			end
		end
	end

	always_ff @(posedge clk) begin
		rsum_s3 <= rs_d;
		acc_s4  <= tot_d;
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_clamp
		if (ch < CH) begin : g_used
			always_comb begin
				logic signed [ACW-1:0] sh;
				sh = acc_s4[ch] >>> rcc_pkg::FRAC_BITS;
				if (acc_s4[ch] < 0) begin
					res[ch] = '0;
				end else if (sh > $signed(ACW'(rcc_pkg::ONE_Q15))) begin
					res[ch] = SW'(rcc_pkg::ONE_Q15);
				end else begin
					res[ch] = SW'(sh);
				end
			end
		end else begin : g_unused
			assign res[ch] = '0;
		end
	end

	// output queue
	assign push     = v_s4_q;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign occ      = 5'(cnt_q) + 5'(v_s1_q) + 5'(v_s2_q) + 5'(v_s3_q) + 5'(v_s4_q);
	assign s_tready = (occ < 5'(FD));

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= {meta_s4.last, meta_s4.col, meta_s4.row, res[2], res[1], res[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FAW'(1);
			end
			cnt_q <= cnt_q + FCW'(push) - FCW'(pop);
		end
	end

	assign m_tdata = {{(rcc_pkg::OUT_DATA_W - FW + 1){1'b0}}, fifo_q[rp_q][FW-2:0]};
	assign m_tlast = fifo_q[rp_q][FW-1];

`include "assert_macros.svh"

	`ASSERT_AT(a_fifo_room, push |-> ((cnt_q < FCW'(FD)) || pop), "output queue overflow")
	`ASSERT_AT(a_ptr_range, WW'(ptr_q) < weff_q, "line pointer beyond width")
	`ASSERT_AT(a_pos_range, (HW'(r_q) < heff_q) && (WW'(c_q) < weff_q), "position outside image")
	`ASSERT_NEVER(a_pre_over, pre_q > lag_q, "startup count passed lag")

endmodule

// File: tb/rgb_conv2d_5x5_clamp_test.sv
// self-checking testbench for rgb_conv2d_5x5_clamp: loads masks and geometry,
// streams raster frames with drain words and compares every output word
// depends on rcc_pkg and the rgb_conv2d_5x5_clamp rtl
module rgb_conv2d_5x5_clamp_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_N = 4 * (1024 + 1) + 1;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [11:0] row;
		logic [9:0]  col;
		logic        last;
	} conv_pixel_t;

	class conv_window_model;
		logic [47:0] line_mem [STORE_N];
		int          coefs [25];
		int          pos;
		int          width_reg;
		int          height_reg;
		conv_pixel_t pending_pixels [$];
		int          errors;

		function new();
			foreach (coefs[i]) coefs[i] = 0;
			foreach (line_mem[i]) line_mem[i] = '0;
			pos = 0;
			width_reg = 1024;
			height_reg = 1024;
			errors = 0;
		endfunction

		function void write_reg(bit idx, int value);
			if (idx == rcc_pkg::REG_WIDTH) width_reg = value & 'h7ff;
			else height_reg = value & 'h1fff;
			pos = 0;
		endfunction

		function void note_input(rcc_pkg::op_t op, logic [71:0] d);
			int w, h, lag, p, q, r, c, nr, nc, off;
			longint acc [3];
			logic [47:0] s;
			conv_pixel_t e;
			if (op == rcc_pkg::OP_COEF) begin
				if (d[52:48] < 25) coefs[d[52:48]] = int'($signed(d[70:53]));
				return;
			end
			if (op == rcc_pkg::OP_NONE) return;
			w = width_reg < 1 ? 1 : (width_reg > 1024 ? 1024 : width_reg);
			h = height_reg < 1 ? 1 : (height_reg > 4096 ? 4096 : height_reg);
			lag = 2 * w + 2;
			p = pos;
			line_mem[p % STORE_N] = (op == rcc_pkg::OP_PIXEL) ? d[47:0] : '0;
			pos = p + 1;
			if (p < lag) return;
			q = p - lag;
			if (q >= w * h) begin
				pos = 0;
				return;
			end
			r = q / w;
			c = q % w;
			acc = '{0, 0, 0};
			for (int i = 0; i < 5; i++)
				for (int j = 0; j < 5; j++) begin
					nr = r + i - 2;
					nc = c + j - 2;
					off = lag - ((i - 2) * w + (j - 2));
					s = (nr >= 0 && nr < h && nc >= 0 && nc < w) ?
						line_mem[(p - off) % STORE_N] : '0;
					for (int k = 0; k < 3; k++)
						acc[k] += longint'(coefs[i * 5 + j]) * longint'(s[16 * k +: 16]);
				end
			for (int k = 0; k < 3; k++) begin
				if (acc[k] < 0) acc[k] = 0;
				else begin
					acc[k] = acc[k] >>> 12;
					if (acc[k] > 32768) acc[k] = 32768;
				end
			end
			e.red = acc[0][15:0];
			e.green = acc[1][15:0];
			e.blue = acc[2][15:0];
			e.row = r[11:0];
			e.col = c[9:0];
			e.last = (q == w * h - 1);
			if (e.last) pos = 0;
			pending_pixels.push_back(e);
		endfunction

		function void check_word(logic [71:0] d, logic last);
			conv_pixel_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected word %h last %b", $time, d, last);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (d[15:0] !== e.red || d[31:16] !== e.green || d[47:32] !== e.blue ||
				d[59:48] !== e.row || d[69:60] !== e.col || last !== e.last) begin
				$display("%0t: mismatch expected r %h g %h b %h row %0d col %0d last %b",
					$time, e.red, e.green, e.blue, e.row, e.col, e.last);
				$display("%0t:          actual   r %h g %h b %h row %0d col %0d last %b",
					$time, d[15:0], d[31:16], d[47:32], d[59:48], d[69:60], last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = rcc_pkg::OP_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = rcc_pkg::REG_WIDTH;
	logic [12:0] cfg_data = '0;

	conv_window_model model = new();
	int send_idle = 0;
	int recv_idle = 0;
	int sent = 0;

	rgb_conv2d_5x5_clamp dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
		if (m_tvalid && m_tready) model.check_word(m_tdata, m_tlast);
	end

	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic put_word(rcc_pkg::op_t op, logic [71:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		model.note_input(op, d);
		sent++;
	endtask

	task automatic put_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		logic [71:0] d;
		d = '0;
		d[15:0] = r;
		d[31:16] = g;
		d[47:32] = b;
		d[70:48] = 23'($urandom);
		put_word(rcc_pkg::OP_PIXEL, d);
	endtask

	task automatic put_coef(logic [4:0] idx, logic [17:0] v);
		logic [71:0] d;
		d = '0;
		d[47:0] = 48'({$urandom, $urandom});
		d[52:48] = idx;
		d[70:53] = v;
		put_word(rcc_pkg::OP_COEF, d);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (model.pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[12:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		model.write_reg(idx, value);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd32768;
			2: return 16'($urandom);
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic [17:0] rand_coef();
		int v;
		if ($urandom_range(3) == 0) return 18'($urandom);
		v = int'($urandom_range(6144)) - 2048;
		return v[17:0];
	endfunction

	task automatic run_frame(int wv, int hv, bit noisy, bit hold);
		int w, h, n;
		logic [71:0] d;
		settle();
		write_reg(rcc_pkg::REG_WIDTH, wv);
		write_reg(rcc_pkg::REG_HEIGHT, hv);
		for (int i = 0; i < 25; i++) put_coef(5'(i), rand_coef());
		w = wv < 1 ? 1 : (wv > 1024 ? 1024 : wv);
		h = hv < 1 ? 1 : (hv > 4096 ? 4096 : hv);
		n = w * h;
		if (noisy && $urandom_range(1)) n = $urandom_range(n);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(9) == 0) begin
				d = 72'({$urandom, $urandom, $urandom});
				d[71] = 1'b0;
				put_word(rcc_pkg::op_t'($urandom_range(1) ? rcc_pkg::OP_NONE : rcc_pkg::OP_COEF),
					d);
			end
			if (hold && i == n / 2) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (model.pending_pixels.size() != 0) @(posedge clk);
			end
			put_pixel(rand_sample(), rand_sample(), rand_sample());
		end
		for (int i = 0; i < 2 * w + 2; i++)
			put_word(rcc_pkg::OP_DRAIN, 72'({$urandom, $urandom, $urandom}));
		if (noisy && $urandom_range(3) == 0)
			for (int i = 0; i < $urandom_range(8); i++)
				put_pixel(rand_sample(), rand_sample(), rand_sample());
	endtask

	initial begin
		int frames;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 34;
		recv_idle = 68;

		// directed: extreme coefficients and samples, ignored ops, bad index
		write_reg(rcc_pkg::REG_WIDTH, 3);
		write_reg(rcc_pkg::REG_HEIGHT, 3);
		put_coef(5'd0, 18'h20000);
		put_coef(5'd12, 18'h1ffff);
		put_coef(5'd24, 18'h01000);
		put_coef(5'd25, 18'h1ffff);
		put_coef(5'd31, 18'h3ffff);
		put_word(rcc_pkg::OP_NONE, {72{1'b1}} >> 1);
		put_pixel(16'd0, 16'd32768, 16'hffff);
		put_pixel(16'hffff, 16'd0, 16'd32768);
		put_pixel(16'd32768, 16'hffff, 16'd0);
		put_pixel(16'd1, 16'd2, 16'd4);
		put_pixel(16'd32768, 16'd32768, 16'd32768);
		put_pixel(16'hffff, 16'hffff, 16'hffff);
		put_pixel(16'd0, 16'd0, 16'd0);
		put_pixel(16'h5555, 16'haaaa, 16'h8000);
		put_pixel(16'h1234, 16'h4321, 16'h0fff);
		for (int i = 0; i < 8; i++) put_word(rcc_pkg::OP_DRAIN, {72{1'b1}} >> 1);

		run_frame(0, 0, 0, 0);
		run_frame(1, 1, 0, 1);
		frames = 0;
		while (sent < 1700) begin
			if (sent > 1150) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (sent > 600) begin
				send_idle = 68;
				recv_idle = 34;
			end
			run_frame($urandom_range(12), $urandom_range(10), $urandom_range(4) == 0,
				frames == 2);
			frames++;
		end
		settle();

		if (model.errors == 0 && model.pending_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rcc_pkg.sv
rtl/core/rcc_ram.sv
rtl/core/rcc_line_buf.sv
rtl/core/rcc_cell.sv
rtl/core/rgb_conv2d_5x5_clamp.sv
tb/rgb_conv2d_5x5_clamp_test.sv
